@@ hw/rtl/dks_pkg.sv @@
// ----------------------------------------------------------------------------
// DES key schedule package
// Shared types, permutation tables and helper functions for the key schedule.
// ----------------------------------------------------------------------------
package dks_pkg;

   localparam int DKS_ROUNDS      = 16;
   localparam int DKS_ROUND_W     = 4;
   localparam int DKS_KEY_W       = 64;
   localparam int DKS_HALF_W      = 28;
   localparam int DKS_CD_W        = 56;
   localparam int DKS_SUBKEY_W    = 48;
   localparam int DKS_RNUM_W      = 5;
   localparam int DKS_QUEUE_DEPTH = 2;

   localparam logic [DKS_ROUND_W-1:0] LAST_ROUND = DKS_ROUND_W'(DKS_ROUNDS - 1);

   // Bit r set: round r rotates both halves by two places, else by one.
   localparam logic [DKS_ROUNDS-1:0] ROT_TWO = 16'h7EFC;

   typedef logic [DKS_HALF_W-1:0]   half_type;
   typedef logic [DKS_SUBKEY_W-1:0] subkey_type;

   typedef struct packed {
      half_type c;
      half_type d;
   } cd_pair_type;

   // Parity-drop permutation: key bit positions, bit 1 is the key MSB.
   localparam logic [6:0] PC1_TABLE [DKS_CD_W] = '{
      7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,
      7'd1,  7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18,
      7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27,
      7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36,
      7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15,
      7'd7,  7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22,
      7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29,
      7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
   };

   // Compression permutation: positions in C:D, bit 1 is the MSB of C.
   localparam logic [5:0] PC2_TABLE [DKS_SUBKEY_W] = '{
      6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,
      6'd3,  6'd28, 6'd15, 6'd6,  6'd21, 6'd10,
      6'd23, 6'd19, 6'd12, 6'd4,  6'd26, 6'd8,
      6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
      6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55,
      6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48,
      6'd44, 6'd49, 6'd39, 6'd56, 6'd34, 6'd53,
      6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
   };

   function automatic cd_pair_type pc1_select(input logic [DKS_KEY_W-1:0] key);
      logic [DKS_CD_W-1:0] cd;
      cd = '0;
      for (int i = 0; i < DKS_CD_W; i++) begin
         cd[DKS_CD_W-1-i] = key[6'(7'd64 - PC1_TABLE[i])];
      end
      return cd_pair_type'(cd);
   endfunction

   function automatic subkey_type pc2_select(input cd_pair_type cd);
      logic [DKS_CD_W-1:0] joined;
      subkey_type          sk;
      joined = cd;
      sk     = '0;
      for (int i = 0; i < DKS_SUBKEY_W; i++) begin
         sk[DKS_SUBKEY_W-1-i] = joined[6'(6'd56 - PC2_TABLE[i])];
      end
      return sk;
   endfunction

   function automatic half_type rotate_half(input half_type h, input logic two);
      return two ? {h[DKS_HALF_W-3:0], h[DKS_HALF_W-1:DKS_HALF_W-2]}
                 : {h[DKS_HALF_W-2:0], h[DKS_HALF_W-1]};
   endfunction

endpackage

@@ hw/rtl/dks_if.sv @@
// ----------------------------------------------------------------------------
// DES key schedule channels
// Valid/ready channels for keys in and subkeys out.
// ----------------------------------------------------------------------------
interface dks_req_if import dks_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [DKS_KEY_W-1:0] cipher_key;

   modport source (output valid, output cipher_key, input ready);
   modport sink   (input valid, input cipher_key, output ready);
endinterface

interface dks_rsp_if import dks_pkg::*; ();
   logic                  valid;
   logic                  ready;
   subkey_type            subkey;
   logic [DKS_RNUM_W-1:0] round_number;
   logic                  final_round;

   modport source (output valid, output subkey, output round_number,
                   output final_round, input ready);
   modport sink   (input valid, input subkey, input round_number,
                   input final_round, output ready);
endinterface

@@ hw/rtl/des_key_schedule_top.sv @@
// ----------------------------------------------------------------------------
// DES key schedule
// Expands each 64-bit key into its sixteen 48-bit round subkeys, in order.
// ----------------------------------------------------------------------------
//
//   channel   direction   item                      per key
//   req_if    in          cipher_key (64 bits)      one item
//   rsp_if    out         subkey, round_number,     sixteen items
//                         final_round
//
// The round engine emits one subkey per cycle while rsp_if is ready, one
// rotation and compression permutation per subkey, and takes the next key as
// the current one emits its last subkey. The first subkey passes the queue,
// the C:D register and the subkey register on its way to rsp_if.
// Reset (synchronous) empties the queue and the engine; nothing else is kept.
// A stalled rsp_if holds the subkey register; keys keep entering until the
// queue between front end and engine is full, then req_if.ready drops.
// ----------------------------------------------------------------------------
module des_key_schedule_top import dks_pkg::*; #(
   parameter int QUEUE_DEPTH = DKS_QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   dks_req_if.sink    req_if,
   dks_rsp_if.source  rsp_if
);

   logic        push_valid, push_ready;
   logic        pop_valid, pop_ready;
   cd_pair_type push_data, pop_data;

   // Front end: drop the parity bits of the incoming item and split C:D.
   dks_front u_front (
      .req        (req_if),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // Decouple key intake from the sixteen-round loop of the engine.
   dks_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // Round engine: advance C and D, emit one subkey item per round.
   dks_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp       (rsp_if)
   );

endmodule

@@ hw/rtl/dks_front.sv @@
// ----------------------------------------------------------------------------
// DES key schedule front end
// Accepts keys, applies the parity-drop permutation and pushes the C:D halves.
// ----------------------------------------------------------------------------
module dks_front import dks_pkg::*; (
   dks_req_if.sink     req,
   output logic        push_valid,
   input  logic        push_ready,
   output cd_pair_type push_data
);

   assign push_valid = req.valid;
   assign req.ready  = push_ready;
   assign push_data  = pc1_select(req.cipher_key);

endmodule

@@ hw/rtl/dks_queue.sv @@
// ----------------------------------------------------------------------------
// DES key schedule queue
// Short FIFO of C:D halves between front end and round engine.
// ----------------------------------------------------------------------------
module dks_queue import dks_pkg::*; #(
   parameter int DEPTH = DKS_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push_valid,
   output logic        push_ready,
   input  cd_pair_type push_data,
   output logic        pop_valid,
   input  logic        pop_ready,
   output cd_pair_type pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cd_pair_type      entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ hw/rtl/dks_back.sv @@
// ----------------------------------------------------------------------------
// DES key schedule round engine; holds while a subkey waits on rsp.ready.
// Rotates C and D once per cycle and registers each compressed round subkey.
// ----------------------------------------------------------------------------
module dks_back import dks_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        pop_valid,
   output logic        pop_ready,
   input  cd_pair_type pop_data,
   dks_rsp_if.source   rsp
);

   logic                   active_ff, active_in;
   logic [DKS_ROUND_W-1:0] round_ff, round_in;
   cd_pair_type            cd_ff, cd_in;
   cd_pair_type            cd_rot;
   logic                   out_valid_ff, out_valid_in;
   subkey_type             subkey_ff;
   logic [DKS_RNUM_W-1:0]  rnum_ff;
   logic                   final_ff;
   logic                   advance, last;

   assign advance = active_ff && (!out_valid_ff || rsp.ready);
   assign last    = (round_ff == LAST_ROUND);
   // Take the next key when idle or as the current one emits its last subkey.
   assign pop_ready = !active_ff || (advance && last);

   assign cd_rot.c = rotate_half(cd_ff.c, ROT_TWO[round_ff]);
   assign cd_rot.d = rotate_half(cd_ff.d, ROT_TWO[round_ff]);

   always_comb begin
      active_in    = active_ff;
      round_in     = round_ff;
      cd_in        = cd_ff;
      out_valid_in = out_valid_ff;
      if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in = 1'b1;
         cd_in        = cd_rot;
         round_in     = round_ff + 1'b1;
         if (last) begin
            active_in = 1'b0;
         end
      end
      if (pop_valid && pop_ready) begin
         active_in = 1'b1;
         round_in  = '0;
         cd_in     = pop_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         round_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         round_ff     <= round_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cd_ff <= cd_in;
      if (advance) begin
         subkey_ff <= pc2_select(cd_rot);
         rnum_ff   <= DKS_RNUM_W'(round_ff) + 1'b1;
         final_ff  <= last;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.subkey       = subkey_ff;
   assign rsp.round_number = rnum_ff;
   assign rsp.final_round  = final_ff;

endmodule
